// ===== src/bse_pkg.sv =====
// Package with the shared constants, item types and state encoding of the bubble sort engine.
`timescale 1ns / 1ps

package bse_pkg;

  // Number of elements the store can hold.
  localparam int unsigned CAPACITY = 16;
  // Width of a store address.
  localparam int unsigned IdxW = $clog2(CAPACITY);
  // Width of the element count, which must also hold CAPACITY itself.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // Width of one stored value.
  localparam int unsigned ValW = 32;

  // One input item.
  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [ValW-1:0] value_res;
    logic                   last_res;
    logic                   overflow;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_FILL,
    ST_PASS,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

endpackage

// ===== src/bubble_sort_engine_unit.sv =====
// Bubble sort engine: collects a set of signed values in a memory, sorts it in place, emits it.
// Sorting: a set of n stored elements takes up to n passes after its last item; a pass that makes
// no swap ends the sort. Each result is then read from memory and loaded into the result register.
// Throughput: one input item per cycle while collecting; no new set is taken until the prior one
// has been sorted and emitted. The element memory has a single read port and a single write port.
// Reset: the element count, the dropped flag and all control clear at once; memory is not cleared.
`timescale 1ns / 1ps

module bubble_sort_engine_unit
  import bse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Element memory with one write port and one registered read port.
  logic [ValW-1:0] mem_q [CAPACITY];
  logic [ValW-1:0] rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [ValW-1:0] mem_wd;
  logic            mem_re;
  logic [IdxW-1:0] mem_ra;

  // Control state.
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            rv_q, rv_d;
  logic [IdxW-1:0] rv_idx_q, rv_idx_d;
  logic            swapped_q, swapped_d;
  logic [IdxW-1:0] emit_idx_q, emit_idx_d;
  logic            out_valid_q, out_valid_d;

  // Payload registers.
  logic [ValW-1:0] held_q, held_d;
  out_item_t       out_item_q, out_item_d;

  // Helper signals.
  logic            in_acc;
  logic            not_full;
  logic [CntW-1:0] count_inc;
  logic [IdxW-1:0] last_idx;
  logic            pass_done;
  logic            out_free;
  logic            load_out;
  logic            emit_last;

  assign in_ready_o  = (state_q == ST_FILL);
  assign in_acc      = in_valid_i && in_ready_o;
  assign not_full    = (count_q < CntW'(CAPACITY));
  assign count_inc   = count_q + CntW'(not_full);
  assign last_idx    = IdxW'(count_q - CntW'(1));
  assign pass_done   = rv_q && (rv_idx_q == last_idx);
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_out    = (state_q == ST_EMIT_LD) && out_free;
  assign emit_last   = (emit_idx_q == last_idx);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc && in_item_i.last) begin
          state_d = (count_inc == CntW'(1)) ? ST_EMIT_RD : ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_done) begin
          state_d = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        state_d = swapped_q ? ST_PASS : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (load_out) begin
          state_d = emit_last ? ST_FILL : ST_EMIT_RD;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // Datapath control, memory ports and result register loading.
  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    rd_idx_d    = rd_idx_q;
    rv_d        = 1'b0;
    rv_idx_d    = rv_idx_q;
    swapped_d   = swapped_q;
    emit_idx_d  = emit_idx_q;
    held_d      = held_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_wa      = count_q[IdxW-1:0];
    mem_wd      = in_item_i.value;
    mem_re      = 1'b0;
    mem_ra      = rd_idx_q[IdxW-1:0];

    unique case (state_q)
      // Store arriving elements in arrival order; drop them once the store is full.
      ST_FILL: begin
        if (in_acc) begin
          mem_we    = not_full;
          count_d   = count_inc;
          dropped_d = dropped_q || !not_full;
          rd_idx_d  = '0;
          swapped_d = 1'b0;
          emit_idx_d = '0;
        end
      end
      // One pass: stream reads ahead and carry the larger value forward.
      ST_PASS: begin
        if (rd_idx_q < count_q) begin
          mem_re   = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
          rv_d     = 1'b1;
          rv_idx_d = rd_idx_q[IdxW-1:0];
        end
        if (rv_q) begin
          if (rv_idx_q == '0) begin
            held_d = rdata_q;
          end else begin
            mem_we = 1'b1;
            mem_wa = rv_idx_q - IdxW'(1);
            if ($signed(held_q) > $signed(rdata_q)) begin
              mem_wd    = rdata_q;
              swapped_d = 1'b1;
            end else begin
              mem_wd = held_q;
              held_d = rdata_q;
            end
          end
        end
      end
      // Write the carried value to the end; start another pass if anything moved.
      ST_PASS_END: begin
        mem_we     = 1'b1;
        mem_wa     = last_idx;
        mem_wd     = held_q;
        rd_idx_d   = '0;
        swapped_d  = 1'b0;
        emit_idx_d = '0;
      end
      ST_EMIT_RD: begin
        mem_re = 1'b1;
        mem_ra = emit_idx_q;
      end
      // Move the read element into the result register once it is free.
      ST_EMIT_LD: begin
        if (load_out) begin
          out_valid_d          = 1'b1;
          out_item_d.value_res = rdata_q;
          out_item_d.last_res  = emit_last;
          out_item_d.overflow  = dropped_q;
          emit_idx_d           = emit_idx_q + IdxW'(1);
          if (emit_last) begin
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_item_q <= out_item_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      rd_idx_q    <= '0;
      rv_q        <= 1'b0;
      rv_idx_q    <= '0;
      swapped_q   <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      rd_idx_q    <= rd_idx_d;
      rv_q        <= rv_d;
      rv_idx_q    <= rv_idx_d;
      swapped_q   <= swapped_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // During a pass a write-back never reaches an entry that is being read.
  a_pass_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS && mem_we && mem_re) |-> (mem_wa < mem_ra))
    else $error("pass write-back overlaps a pending read");

  // The element count never exceeds the store capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  // Emitting the final sorted item returns the block to collection with an empty store.
  a_emit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && emit_last) |=> (state_q == ST_FILL && count_q == '0 && !dropped_q))
    else $error("set not closed after its final item");
`endif

endmodule

// ===== test/tb_bubble_sort_engine_unit.sv =====
// Self-checking testbench for the bubble sort engine: random and directed sets, sorted results.
`timescale 1ns / 1ps

module tb_bubble_sort_engine_unit;
  import bse_pkg::*;

  // Cycles in a row with no item moving on either channel before the run is abandoned.
  localparam int unsigned StallLimit = 5000;
  // Quiet cycles allowed after the last sorted result has come out.
  localparam int unsigned DrainCycles = 400;
  // Number of random input items to send.
  localparam int unsigned RandItems = 410;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  // Kinds of content for a random set.
  typedef enum int {
    MIX_WIDE,
    MIX_NARROW,
    MIX_EXTREME,
    MIX_ASCENDING
  } value_mix_e;

  // Collects a set as it is accepted and sorts it on its last item; checks what comes out.
  class sort_scoreboard;
    logic signed [ValW-1:0] held[$];
    bit                     dropped;
    out_item_t              sorted_expect[$];
    int unsigned            fail_count;

    function void add_element(in_item_t it);
      logic signed [ValW-1:0] tmp;
      bit                     swapped;
      int                     n;
      out_item_t              r;
      // A full store drops the element but remembers that it did.
      if (held.size() < CAPACITY) begin
        held.insert(held.size(), it.value);
      end else begin
        dropped = 1'b1;
      end
      if (!it.last) return;
      // Adjacent compare-and-swap passes until one pass changes nothing.
      n = held.size();
      swapped = 1'b1;
      while (swapped) begin
        swapped = 1'b0;
        for (int k = 0; k + 1 < n; k++) begin
          if (held[k] > held[k+1]) begin
            tmp = held[k];
            held[k] = held[k+1];
            held[k+1] = tmp;
            swapped = 1'b1;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        r.value_res = held[k];
        r.last_res  = (k == n - 1);
        r.overflow  = dropped;
        sorted_expect.insert(sorted_expect.size(), r);
      end
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_emitted(out_item_t got);
      out_item_t want;
      if (sorted_expect.size() == 0) begin
        $error("unexpected sorted item: value_res %0d last_res %0b overflow %0b",
               got.value_res, got.last_res, got.overflow);
        fail_count++;
        return;
      end
      want = sorted_expect.pop_front();
      if (got.value_res !== want.value_res) begin
        $error("value_res: expected %0d, actual %0d", want.value_res, got.value_res);
        fail_count++;
      end
      if (got.last_res !== want.last_res) begin
        $error("last_res: expected %0b, actual %0b", want.last_res, got.last_res);
        fail_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
        fail_count++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  sort_scoreboard board = new;
  // While set, neither side inserts idle cycles.
  bit          calm = 1'b0;
  int unsigned stall_cycles = 0;

  bubble_sort_engine_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random outside the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 32);
  end

  // Every accepted result is checked against the oldest sorted value still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_emitted(out_item_o);
    end
  end

  // Give up when nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb_bubble_sort_engine_unit failed");
      $finish;
    end
  end

  // Offer one item, with random idle cycles first, and hold it until it is taken.
  task automatic send_item(logic signed [ValW-1:0] v, logic l);
    in_item_t it;
    it.value = v;
    it.last  = l;
    while (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.add_element(it);
  endtask

  // Hold the input side quiet until every owed result has come out.
  task automatic wait_sorted_out();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.sorted_expect.size() != 0);
  endtask

  function automatic logic signed [ValW-1:0] pick_value(value_mix_e mix, int pos);
    case (mix)
      MIX_WIDE:   return $urandom;
      MIX_NARROW: return int'($urandom_range(8)) - 4;
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0:       return ValMax;
          1:       return ValMin;
          2:       return 0;
          default: return -1;
        endcase
      end
      default:    return pos * 1000 - 5000 + int'($urandom_range(999));
    endcase
  endfunction

  initial begin
    int unsigned rand_sent;
    int unsigned set_idx;
    int unsigned len;
    int unsigned pick;
    value_mix_e  mix;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A set of one element.
    send_item(ValMax, 1'b1);
    // Both extremes, a repeated minimum and values around zero.
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(ValMin, 1'b0);
    send_item(ValMax, 1'b0);
    send_item(ValMin, 1'b1);
    // Descending fill of the whole store; the closing item finds it full and is dropped.
    for (int i = 0; i <= CAPACITY; i++) begin
      send_item(CAPACITY - i, i == CAPACITY);
    end
    wait_sorted_out();

    // Random sets: mostly within capacity, some exactly full, some overflowing.
    rand_sent = 0;
    set_idx = 0;
    while (rand_sent < RandItems) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = CAPACITY + 1 + $urandom_range(3);
      end else if (pick < 20) begin
        len = CAPACITY;
      end else if (pick < 35) begin
        len = 1 + $urandom_range(2);
      end else begin
        len = 1 + $urandom_range(CAPACITY - 1);
      end
      mix = value_mix_e'($urandom_range(3));
      calm = (set_idx >= 12 && set_idx < 20);
      for (int i = 0; i < len; i++) begin
        send_item(pick_value(mix, i), i == len - 1);
      end
      rand_sent += len;
      set_idx++;
      if ($urandom_range(7) == 0) begin
        wait_sorted_out();
      end
    end
    calm = 1'b0;

    wait_sorted_out();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.sorted_expect.size() != 0) begin
      $error("%0d sorted items never came out", board.sorted_expect.size());
      board.fail_count++;
    end
    if (board.fail_count == 0) begin
      $display("tb_bubble_sort_engine_unit passed");
    end else begin
      $display("tb_bubble_sort_engine_unit failed");
    end
    $finish;
  end

endmodule
